// ----- rtl/core/ipv4_fragment_option_compactor_assert.svh -----
// Assertion macros for the IPv4 fragment option compactor.
// Used by the top level; expects signals named clock and reset in scope.
`ifndef IPV4_FRAGMENT_OPTION_COMPACTOR_ASSERT_SVH
`define IPV4_FRAGMENT_OPTION_COMPACTOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IPFOC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ipfoc same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define IPFOC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ipfoc next-cycle check failed");

`endif

// ----- rtl/core/ipfoc_pkg.sv -----
// Shared types and constants for the IPv4 fragment option compactor.
// No dependencies.
package ipfoc_pkg;

   localparam int unsigned MAX_OPTION_BYTES = 40;
   localparam logic [1:0]  ALIGN_MASK       = 2'h3;
   localparam logic [3:0]  BASE_WORDS       = 4'd5;
   localparam logic [7:0]  OPT_EOL          = 8'd0;
   localparam logic [7:0]  OPT_NOP          = 8'd1;
   localparam logic [7:0]  MIN_OPT_LEN      = 8'd2;
   localparam logic [5:0]  BODY_MAX         = 6'd63;

   typedef enum logic [1:0] {
      PHASE_TYPE = 2'd0,
      PHASE_LEN  = 2'd1,
      PHASE_BODY = 2'd2,
      PHASE_END  = 2'd3
   } walk_phase_type;

   // One finished per-byte result, from the walker to the output register.
   typedef struct packed {
      logic       keep_valid;
      logic [7:0] kept_byte;
      logic       header_done;
      logic [1:0] pad_count;
      logic [3:0] header_words;
   } result_type;

endpackage

// ----- rtl/core/ipfoc_walk.sv -----
// Option walker: per-header walk state and the per-byte result logic.
// Depends on ipfoc_pkg.
module ipfoc_walk
   import ipfoc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic [7:0] option_byte,
   input  logic       area_last,
   output result_type result
);

   walk_phase_type walk_phase_ff, walk_phase_in;
   logic [5:0]     body_remaining_ff, body_remaining_in;
   logic           copy_current_ff, copy_current_in;
   logic [5:0]     kept_count_ff, kept_count_in;

   logic       keep_raw;
   logic       keep;
   logic [5:0] kept_next;
   logic [5:0] body_dec;
   logic [7:0] body_len;
   logic [1:0] pad;
   logic [6:0] padded;

   // Next state of the walk.
   always_comb begin
      walk_phase_in     = walk_phase_ff;
      body_remaining_in = body_remaining_ff;
      copy_current_in   = copy_current_ff;
      keep_raw          = 1'b0;
      body_len          = option_byte - MIN_OPT_LEN;
      body_dec          = (body_remaining_ff != 6'd0) ? body_remaining_ff - 6'd1 : 6'd0;
      case (walk_phase_ff)
         PHASE_TYPE: begin
            if (option_byte == OPT_EOL) begin
               walk_phase_in = PHASE_END;
            end else if (option_byte != OPT_NOP) begin
               copy_current_in = option_byte[7];
               keep_raw        = option_byte[7];
               walk_phase_in   = PHASE_LEN;
            end
         end
         PHASE_LEN: begin
            if (option_byte < MIN_OPT_LEN) begin
               walk_phase_in = PHASE_END;
            end else begin
               keep_raw          = copy_current_ff;
               body_remaining_in = (body_len > {2'b00, BODY_MAX}) ? BODY_MAX : body_len[5:0];
               walk_phase_in     = (body_remaining_in == 6'd0) ? PHASE_TYPE : PHASE_BODY;
            end
         end
         PHASE_BODY: begin
            keep_raw          = copy_current_ff;
            body_remaining_in = body_dec;
            if (body_dec == 6'd0) begin
               walk_phase_in = PHASE_TYPE;
            end
         end
         default: begin
         end
      endcase
   end

   // Kept-byte budget, padding and header length.
   always_comb begin
      keep      = keep_raw && (kept_count_ff < 6'(MAX_OPTION_BYTES));
      kept_next = kept_count_ff + {5'd0, keep};
      pad       = (~kept_next[1:0] + 2'd1) & ALIGN_MASK;
      padded    = {1'b0, kept_next} + {5'd0, pad};
      kept_count_in = area_last ? 6'd0 : kept_next;

      result.keep_valid   = keep;
      result.kept_byte    = keep ? option_byte : 8'd0;
      result.header_done  = area_last;
      result.pad_count    = area_last ? pad : 2'd0;
      result.header_words = area_last ? BASE_WORDS + padded[5:2] : 4'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walk_phase_ff     <= PHASE_TYPE;
         body_remaining_ff <= 6'd0;
         copy_current_ff   <= 1'b0;
         kept_count_ff     <= 6'd0;
      end else if (advance) begin
         if (area_last) begin
            walk_phase_ff     <= PHASE_TYPE;
            body_remaining_ff <= 6'd0;
            copy_current_ff   <= 1'b0;
         end else begin
            walk_phase_ff     <= walk_phase_in;
            body_remaining_ff <= body_remaining_in;
            copy_current_ff   <= copy_current_in;
         end
         kept_count_ff <= kept_count_in;
      end
   end

endmodule

// ----- rtl/core/ipfoc_out_reg.sv -----
// Result register feeding the rsp stream; holds a result while stalled.
// Depends on ipfoc_pkg.
module ipfoc_out_reg
   import ipfoc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  result_type result,
   input  logic       rsp_tready,
   output logic       rsp_tvalid,
   output result_type held
);

   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff;

   always_comb begin
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign held       = out_data_ff;

endmodule

// ----- rtl/core/ipv4_fragment_option_compactor.sv -----
// Top level of the IPv4 fragment option compactor: input register, walker, result register.
// Depends on ipfoc_pkg, ipfoc_walk, ipfoc_out_reg and the assertion macro header.
//
//  channel | direction | tdata                                   | tuser      | tlast
//  --------+-----------+-----------------------------------------+------------+------------
//  req     | in        | [7:0] option_byte                       | -          | area_last
//  rsp     | out       | [7:0] kept_byte [9:8] pad_count         | keep_valid | header_done
//          |           | [13:10] header_words [15:14] zero       |            |
//
// One transaction in, one out: a byte can be accepted every cycle while rsp is not stalled.
// Its result passes from the input register into the result register and shows on rsp.
// The walk state advances once per byte moved from the input to the result register.
// Reset is synchronous, active high; it empties both registers and returns the
// walk to "expect option type". A stall on rsp backs up into req only when both
// registers hold a transaction; otherwise req keeps flowing.
module ipv4_fragment_option_compactor
   import ipfoc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] option_byte
   input  logic        req_tlast,   // area_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] kept_byte, [9:8] pad_count, [13:10] header_words
   output logic        rsp_tuser,   // keep_valid
   output logic        rsp_tlast    // header_done
);

`include "ipv4_fragment_option_compactor_assert.svh"

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance;
   result_type result;
   result_type held;

   // Byte leaves the input register when the result register is free or draining.
   assign advance    = in_valid_ff && (!rsp_tvalid || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   ipfoc_walk u_walk (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .option_byte (in_byte_ff),
      .area_last   (in_last_ff),
      .result      (result)
   );

   ipfoc_out_reg u_out (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .result     (result),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .held       (held)
   );

   assign rsp_tdata = {2'b00, held.header_words, held.pad_count, held.kept_byte};
   assign rsp_tuser = held.keep_valid;
   assign rsp_tlast = held.header_done;

   // Dropped bytes come out as zero.
   `IPFOC_ASSERT_NOW(a_drop_zero, rsp_tvalid && !rsp_tuser, rsp_tdata[7:0] == 8'd0)
   // Padding and length are only reported on the last byte.
   `IPFOC_ASSERT_NOW(a_tail_only, rsp_tvalid && !rsp_tlast, rsp_tdata[13:8] == 6'd0)
   // A byte held in the input register is never lost while the output stalls.
   `IPFOC_ASSERT_NEXT(a_in_hold, in_valid_ff && !advance, in_valid_ff && $stable(in_byte_ff))

endmodule

// ----- tb/ipv4_fragment_option_compactor_tb.sv -----
// Self-checking testbench for the IPv4 fragment option compactor.
// Needs ipfoc_pkg and the ipv4_fragment_option_compactor RTL; no other files.
// Option areas go in on req, and each rsp transaction is checked against an option-walk predictor.
module ipv4_fragment_option_compactor_tb;
   import ipfoc_pkg::*;

   localparam int CYCLE_LIMIT = 100000;   // far above the slowest legal run
   localparam int TAIL_CYCLES = 6;        // two-register pipe plus margin
   localparam int MAX_REPORTS = 50;       // cap on printed mismatch lines

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] option_byte
   logic        req_tlast;    // area_last
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // [7:0] kept_byte, [9:8] pad_count, [13:10] header_words
   logic        rsp_tuser;    // keep_valid
   logic        rsp_tlast;    // header_done

   ipv4_fragment_option_compactor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Clock: period 10.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ------------------------------------------------------------------
   // Shared state
   // ------------------------------------------------------------------
   int          error_count    = 0;
   int          cycle_count    = 0;
   int          bytes_sent     = 0;
   int          results_seen   = 0;
   bit          quiet_mode     = 1'b0;  // 1: neither side idles
   logic [7:0]  area_bytes[$];          // option area being built for the next send
   result_type  pending_results[$];     // expected rsp transactions, oldest first

   // Option-walk predictor state; mirrors the block's walk registers.
   walk_phase_type walk_phase_m;
   logic [5:0]     body_left;
   logic           copy_flag;
   logic [5:0]     kept_total;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic void clear_option_walk();
      walk_phase_m = PHASE_TYPE;
      body_left    = '0;
      copy_flag    = 1'b0;
      kept_total   = '0;
   endfunction

   // Advances the walk by one option byte and returns the result it causes.
   function automatic result_type predict_option_byte(input logic [7:0] opt_byte,
                                                      input logic       area_end);
      result_type  r;
      logic        keep;
      logic [1:0]  pad;
      logic [7:0]  body_len;
      r    = '0;
      keep = 1'b0;
      pad  = 2'd0;
      case (walk_phase_m)
         PHASE_TYPE: begin
            if (opt_byte == OPT_EOL) begin
               walk_phase_m = PHASE_END;
            end else if (opt_byte != OPT_NOP) begin
               copy_flag    = opt_byte[7];
               keep         = opt_byte[7];
               walk_phase_m = PHASE_LEN;
            end
         end
         PHASE_LEN: begin
            // length below two ends the walk; the length byte is dropped
            if (opt_byte < MIN_OPT_LEN) begin
               walk_phase_m = PHASE_END;
            end else begin
               body_len     = opt_byte - MIN_OPT_LEN;
               keep         = copy_flag;
               body_left    = (body_len > BODY_MAX) ? BODY_MAX : body_len[5:0];
               walk_phase_m = (body_left == 0) ? PHASE_TYPE : PHASE_BODY;
            end
         end
         PHASE_BODY: begin
            keep = copy_flag;
            if (body_left != 0) body_left = body_left - 1'b1;
            if (body_left == 0) walk_phase_m = PHASE_TYPE;
         end
         default: ;
      endcase
      if (keep && kept_total >= MAX_OPTION_BYTES) keep = 1'b0;
      if (keep) kept_total = kept_total + 1'b1;
      r.keep_valid  = keep;
      r.kept_byte   = keep ? opt_byte : 8'd0;
      r.header_done = area_end;
      if (area_end) begin
         pad            = (2'd0 - kept_total[1:0]) & ALIGN_MASK;
         r.pad_count    = pad;
         r.header_words = BASE_WORDS + 4'((int'(kept_total) + int'(pad)) >> 2);
         clear_option_walk();
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Mismatch reporting
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input int got, input int want_v);
      if (error_count < MAX_REPORTS)
         $display("MISMATCH %s: got %0d, expected %0d (rsp transaction %0d)",
                  what, got, want_v, results_seen);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // Monitor: predicts on every accepted req transaction, checks every
   // accepted rsp transaction. Both are sampled at the clock edge, before
   // any nonblocking update of that edge lands.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : check_results
      result_type want;
      if (reset) begin
         clear_option_walk();
      end else begin
         // push first: a result never leaves in the cycle its byte enters
         if (req_tvalid && req_tready)
            pending_results.push_back(predict_option_byte(req_tdata, req_tlast));
         if (rsp_tvalid && rsp_tready) begin
            if (pending_results.size() == 0) begin
               report_mismatch("rsp transaction with none pending", 1, 0);
            end else begin
               want = pending_results.pop_front();
               if (rsp_tuser !== want.keep_valid)
                  report_mismatch("keep_valid", rsp_tuser, want.keep_valid);
               if (rsp_tdata[7:0] !== want.kept_byte)
                  report_mismatch("kept_byte", rsp_tdata[7:0], want.kept_byte);
               if (rsp_tlast !== want.header_done)
                  report_mismatch("header_done", rsp_tlast, want.header_done);
               if (rsp_tdata[9:8] !== want.pad_count)
                  report_mismatch("pad_count", rsp_tdata[9:8], want.pad_count);
               if (rsp_tdata[13:10] !== want.header_words)
                  report_mismatch("header_words", rsp_tdata[13:10], want.header_words);
               if (rsp_tdata[15:14] !== 2'b00)
                  report_mismatch("tdata fill bits", rsp_tdata[15:14], 0);
            end
            results_seen++;
         end
      end
   end

   // Receiver: stalls at random, about 7 percent of the time, unless quiet.
   always @(posedge clock)
      rsp_tready <= quiet_mode || ($urandom_range(99) >= 7);

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Sender
   // ------------------------------------------------------------------
   // One req transaction. tvalid stays high on return so back-to-back bytes
   // never see a low/high pair of updates in one time step.
   task automatic send_option_byte(input logic [7:0] opt_byte, input logic area_end);
      if (!quiet_mode && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= opt_byte;
      req_tlast  <= area_end;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // Sends area_bytes as one option area, tlast on its final byte.
   task automatic send_area();
      foreach (area_bytes[i])
         send_option_byte(area_bytes[i], i == area_bytes.size() - 1);
   endtask

   // Drops tvalid, then blocks until every expected rsp transaction has been seen.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // ------------------------------------------------------------------
   // Area builders
   // ------------------------------------------------------------------
   // Well-formed option list with random content, 1..40 bytes nominal.
   task automatic build_formed_area();
      int         target;
      int         room;
      int         pick;
      int         opt_len;
      logic [7:0] opt_type;
      area_bytes.delete();
      target = $urandom_range(1, 40);
      while (area_bytes.size() < target) begin
         pick = $urandom_range(99);
         room = target - area_bytes.size();
         if (pick < 12) begin
            area_bytes.push_back(OPT_NOP);
         end else if (pick < 17) begin
            // EOL, then trailing junk that must be dropped
            area_bytes.push_back(OPT_EOL);
            while (area_bytes.size() < target) area_bytes.push_back(8'($urandom));
         end else begin
            opt_type = 8'($urandom);
            if (opt_type[6:0] < 2) opt_type[1] = 1'b1;
            opt_len = $urandom_range(2, (room < 2) ? 2 : room);
            area_bytes.push_back(opt_type);
            area_bytes.push_back(8'(opt_len));
            repeat (opt_len - 2) area_bytes.push_back(8'($urandom));
         end
      end
   endtask

   // Truncated options, bad lengths, or plain noise.
   task automatic build_broken_area();
      int n;
      case ($urandom_range(2))
         0: begin
            build_formed_area();
            n = $urandom_range(1, area_bytes.size());
            while (area_bytes.size() > n) void'(area_bytes.pop_back());
         end
         1: begin
            build_formed_area();
            // a type byte followed by a length below two
            n = $urandom_range(0, area_bytes.size() - 1);
            area_bytes.insert(n, 8'($urandom_range(0, 1)));
            area_bytes.insert(n, 8'($urandom_range(2, 255)));
         end
         default: begin
            area_bytes.delete();
            repeat ($urandom_range(1, 16)) area_bytes.push_back(8'($urandom));
         end
      endcase
   endtask

   // Long area led by a big copied option: hits the 40-byte keep cap.
   task automatic build_long_area(input bit max_len);
      int target;
      area_bytes.delete();
      target = $urandom_range(45, 90);
      area_bytes.push_back(8'h80 | 8'($urandom_range(2, 127)));
      area_bytes.push_back(max_len ? 8'hFF : 8'($urandom_range(42, 254)));
      while (area_bytes.size() < target) area_bytes.push_back(8'($urandom));
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Hand-picked areas: EOL alone, NOP run, copied and uncopied options,
   // length below two, zero length, overrun at the area end, bytes after EOL.
   task automatic test_directed_options();
      area_bytes = '{8'h00};                                   send_area();
      area_bytes = '{8'h01, 8'h01, 8'h01, 8'h01};              send_area();
      area_bytes = '{8'h83, 8'h04, 8'hFF, 8'h00, 8'h00};       send_area();
      area_bytes = '{8'h07, 8'h03, 8'hAB, 8'h94, 8'h02};       send_area();
      area_bytes = '{8'h89, 8'h01, 8'hAA};                     send_area();
      area_bytes = '{8'h44, 8'h00};                            send_area();
      area_bytes = '{8'h82, 8'h0A, 8'h80, 8'h7F};              send_area();
      area_bytes = '{8'h00, 8'h83, 8'h03, 8'h01};              send_area();
   endtask

   // Mostly well-formed option lists, some broken ones and noise.
   task automatic test_random_areas(input int byte_goal);
      while (bytes_sent < byte_goal) begin
         if ($urandom_range(99) < 80) build_formed_area();
         else build_broken_area();
         send_area();
      end
   endtask

   // Sender holds off until the pipe is empty, then resumes.
   task automatic test_drain_pause();
      wait_for_drain();
      build_formed_area();
      send_area();
      wait_for_drain();
      build_formed_area();
      send_area();
   endtask

   // Long stretch with neither side idling.
   task automatic test_back_to_back(input int byte_count);
      int goal;
      goal       = bytes_sent + byte_count;
      quiet_mode = 1'b1;
      while (bytes_sent < goal) begin
         build_formed_area();
         send_area();
      end
      quiet_mode = 1'b0;
   endtask

   // Keep cap, long body held at 63, full-size header.
   task automatic test_long_areas();
      build_long_area(1'b1);
      send_area();
      repeat (3) begin
         build_long_area(1'b0);
         send_area();
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed_options();
      test_random_areas(480);
      test_drain_pause();
      test_back_to_back(150);
      test_long_areas();
      test_random_areas(930);

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ----- ipv4_fragment_option_compactor.f -----
+incdir+rtl/core
rtl/core/ipfoc_pkg.sv
rtl/core/ipfoc_walk.sv
rtl/core/ipfoc_out_reg.sv
rtl/core/ipv4_fragment_option_compactor.sv
tb/ipv4_fragment_option_compactor_tb.sv
